// ===== sv/ljpf_pkg.sv =====
// Shared types and constants for the Lennard-Jones pair force pipeline.
// No dependencies.
package ljpf_pkg;

  localparam int CoordWidth    = 24;
  localparam int ForceWidth    = 32;
  localparam int CutoffWidth   = 31;
  localparam int StrengthWidth = 16;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 32;
  localparam int InvFrac       = 24;

  localparam logic [CfgIndexWidth-1:0] CfgBoxLength     = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgCutoffSquared = 2'd1;

  localparam logic [CoordWidth-1:0]  BoxReset    = CoordWidth'(1680980);
  localparam logic [CutoffWidth-1:0] CutoffReset = CutoffWidth'(262144);
  localparam logic [31:0]            FloorQ32    = 32'd42949672;

  localparam logic signed [ForceWidth-1:0] ForceMax = {1'b0, {(ForceWidth-1){1'b1}}};
  localparam logic signed [ForceWidth-1:0] ForceMin = {1'b1, {(ForceWidth-1){1'b0}}};

  typedef struct packed {
    logic [CoordWidth-1:0]    pos_i_x;
    logic [CoordWidth-1:0]    pos_i_y;
    logic [CoordWidth-1:0]    pos_i_z;
    logic [CoordWidth-1:0]    pos_j_x;
    logic [CoordWidth-1:0]    pos_j_y;
    logic [CoordWidth-1:0]    pos_j_z;
    logic [StrengthWidth-1:0] strength_i;
    logic [StrengthWidth-1:0] strength_j;
  } pair_in_t;

  typedef struct packed {
    logic signed [ForceWidth-1:0] force_x;
    logic signed [ForceWidth-1:0] force_y;
    logic signed [ForceWidth-1:0] force_z;
    logic                         in_range;
    logic                         saturated;
  } pair_out_t;

endpackage

// ===== sv/ljpf_delay.sv =====
// Enabled shift-register delay line for pipeline sideband data.
// No dependencies.
module ljpf_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[N-1];
endmodule

// ===== sv/ljpf_mul.sv =====
// Two-stage unsigned multiplier: 32x32 partial products, then a registered sum.
// No dependencies.
module ljpf_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic [AW+BW-1:0] p_o
);
  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int SW = (NA + NB) * 32;

  logic [NA*32-1:0] a_pad;
  logic [NB*32-1:0] b_pad;
  logic [63:0]      pp_q [NA*NB];
  logic [SW-1:0]    acc;
  logic [AW+BW-1:0] p_q;

  assign a_pad = (NA*32)'(a_i);
  assign b_pad = (NB*32)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i*NB+j] <= a_pad[i*32 +: 32] * b_pad[j*32 +: 32];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp_q[i*NB+j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= acc[AW+BW-1:0];
    end
  end

  assign p_o = p_q;
endmodule

// ===== sv/ljpf_recip.sv =====
// Pipelined restoring divider: floor(2^NUM_EXP / divisor), one quotient bit per stage.
// No dependencies. Quotient is valid when it fits QW bits.
module ljpf_recip #(
  parameter int DW      = 50,
  parameter int QW      = 31,
  parameter int NUM_EXP = 56
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] div_i,
  output logic [QW-1:0] quo_o
);
  localparam int RW = DW + 1;

  logic [RW-1:0] rem_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [DW-1:0] div_q [QW+1];
  logic [RW-1:0] rem_s [QW];
  logic [QW-1:0] quo_s [QW];
  logic [DW-1:0] div_s [QW];
  logic [RW-1:0] rem_n [QW];
  logic [QW-1:0] quo_n [QW];

  always_comb begin
    rem_s[0] = RW'(1) << (NUM_EXP - QW);
    quo_s[0] = '0;
    div_s[0] = div_i;
    for (int i = 1; i < QW; i++) begin
      rem_s[i] = rem_q[i];
      quo_s[i] = quo_q[i];
      div_s[i] = div_q[i];
    end
    for (int i = 0; i < QW; i++) begin
      logic [RW-1:0] sh;
      sh = {rem_s[i][RW-2:0], 1'b0};
      if (sh >= RW'(div_s[i])) begin
        rem_n[i] = sh - RW'(div_s[i]);
        quo_n[i] = {quo_s[i][QW-2:0], 1'b1};
      end else begin
        rem_n[i] = sh;
        quo_n[i] = {quo_s[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QW; i++) begin
        rem_q[i+1] <= rem_n[i];
        quo_q[i+1] <= quo_n[i];
        div_q[i+1] <= div_s[i];
      end
    end
  end

  assign quo_o = quo_q[QW];
endmodule

// ===== sv/ljpf_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// No dependencies.
module ljpf_sqrt #(
  parameter int XW = 36
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [XW-1:0]         x_i,
  output logic [(XW+1)/2-1:0]   root_o
);
  localparam int RW = (XW + 1) / 2;
  localparam int TW = 2 * RW + 2;

  logic [TW-1:0] rem_q  [RW+1];
  logic [RW-1:0] root_q [RW+1];
  logic [TW-1:0] rem_s  [RW];
  logic [RW-1:0] root_s [RW];
  logic [TW-1:0] rem_n  [RW];
  logic [RW-1:0] root_n [RW];

  always_comb begin
    rem_s[0]  = TW'(x_i);
    root_s[0] = '0;
    for (int i = 1; i < RW; i++) begin
      rem_s[i]  = rem_q[i];
      root_s[i] = root_q[i];
    end
    for (int i = 0; i < RW; i++) begin
      logic [TW-1:0] trial;
      trial = (TW'(root_s[i]) << (RW - i)) + (TW'(1) << (2 * (RW - 1 - i)));
      if (trial <= rem_s[i]) begin
        rem_n[i]  = rem_s[i] - trial;
        root_n[i] = root_s[i] | (RW'(1) << (RW - 1 - i));
      end else begin
        rem_n[i]  = rem_s[i];
        root_n[i] = root_s[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < RW; i++) begin
        rem_q[i+1]  <= rem_n[i];
        root_q[i+1] <= root_n[i];
      end
    end
  end

  assign root_o = root_q[RW];
endmodule

// ===== sv/lennard_jones_pair_force.sv =====
// Top level of the Lennard-Jones pair force pipeline with cutoff.
// Depends on ljpf_pkg, ljpf_delay, ljpf_mul, ljpf_recip, ljpf_sqrt.
//
//   channel | dir | handshake                  | payload
//   in      | in  | in_valid_i / in_ready_o    | in_data_i  (pair_in_t)
//   out     | out | out_valid_o / out_ready_i  | out_data_o (pair_out_t)
//   cfg     | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One pair per cycle; each result's path runs through the 31-stage reciprocal
// divider and the multiplier chain behind it.
// The whole pipeline advances together and halts only while a result waits.
// Reset clears the valid bits and loads the register reset values; the
// config channel is always ready.
module lennard_jones_pair_force (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  ljpf_pkg::pair_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output ljpf_pkg::pair_out_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ljpf_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [ljpf_pkg::CfgDataWidth-1:0]    cfg_data_i
);
  import ljpf_pkg::*;

  localparam int DiffW  = CoordWidth + 2;
  localparam int SqW    = 49;
  localparam int R2W    = 50;
  localparam int QW     = 31;
  localparam int S2W    = 2 * QW - InvFrac;
  localparam int S3W    = S2W + QW - InvFrac;
  localparam int S4W    = 2 * S2W - InvFrac;
  localparam int TW     = S3W + 1;
  localparam int XW     = 2 * StrengthWidth + 4;
  localparam int EpsW   = (XW + 1) / 2;
  localparam int Eps24W = EpsW + 5;
  localparam int AW     = Eps24W + TW;
  localparam int BW     = S4W + CoordWidth;
  localparam int PW     = AW + BW;
  localparam int HiW    = PW - 64;
  localparam int Lat    = 44;

  logic en;
  logic [Lat:1] vld_q;

  logic [CoordWidth-1:0]  box_q;
  logic [CutoffWidth-1:0] cut_q;

  logic [CoordWidth-1:0] pi [3];
  logic [CoordWidth-1:0] pj [3];

  logic signed [DiffW-1:0] d_q [3];
  logic [31:0]             sprod_q;
  logic [CoordWidth-1:0]   mag_q [3];
  logic [2:0]              neg_q;
  logic [SqW-1:0]          sq_q [3];
  logic [XW-1:0]           xs_q;
  logic [R2W-1:0]          r2_q;
  logic                    inr_q;

  logic [QW-1:0]        s, s_d;
  logic [2*QW-1:0]      s2_full;
  logic [S2W-1:0]       s2;
  logic [S2W+QW-1:0]    s3_full;
  logic [2*S2W-1:0]     s4_full;
  logic [S3W-1:0]       s3;
  logic [TW-1:0]        tmag_q;
  logic                 negt_q;
  logic [EpsW-1:0]      eps, eps_d;
  logic [Eps24W-1:0]    eps24;
  logic [AW-1:0]        a;
  logic [PW-1:0]        prod [3];
  logic [CoordWidth-1:0] mag_d [3];
  logic [2:0]           neg_d;
  logic                 negt_d;
  logic                 inr_d;
  pair_out_t            out_q;

  function automatic logic signed [DiffW-1:0] wrap_diff(
    logic [CoordWidth-1:0] p, logic [CoordWidth-1:0] q, logic [CoordWidth-1:0] bx);
    logic signed [DiffW:0] d;
    logic signed [DiffW:0] bs;
    d  = $signed((DiffW+1)'(p)) - $signed((DiffW+1)'(q));
    bs = $signed((DiffW+1)'(bx));
    if ((d <<< 1) > bs) d = d - bs;
    if ((d <<< 1) < -bs) d = d + bs;
    return DiffW'(d);
  endfunction

  assign en          = !vld_q[Lat] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Lat];
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= BoxReset;
      cut_q <= CutoffReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgBoxLength) box_q <= cfg_data_i[CoordWidth-1:0];
      if (cfg_index_i == CfgCutoffSquared) cut_q <= cfg_data_i[CutoffWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-1:1], in_valid_i};
    end
  end

  assign pi[0] = in_data_i.pos_i_x;
  assign pi[1] = in_data_i.pos_i_y;
  assign pi[2] = in_data_i.pos_i_z;
  assign pj[0] = in_data_i.pos_j_x;
  assign pj[1] = in_data_i.pos_j_y;
  assign pj[2] = in_data_i.pos_j_z;

  // stages 1-3: wrap, square, range test
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [CoordWidth-1:0] m;
        logic [24:0]           c;
        d_q[k] <= wrap_diff(pi[k], pj[k], box_q);
        m = d_q[k][DiffW-1] ? CoordWidth'(-d_q[k]) : CoordWidth'(d_q[k]);
        c = ((CoordWidth + 1)'(m) > (CoordWidth + 1)'(25'h1000000)) ? 25'h1000000 : 25'(m);
        mag_q[k] <= m;
        neg_q[k] <= d_q[k][DiffW-1];
        sq_q[k]  <= SqW'(c) * SqW'(c);
      end
      sprod_q <= in_data_i.strength_i * in_data_i.strength_j;
      xs_q    <= {sprod_q, 4'b0};
      r2_q    <= R2W'(sq_q[0]) + R2W'(sq_q[1]) + R2W'(sq_q[2]);
      inr_q   <= ((R2W'(sq_q[0]) + R2W'(sq_q[1]) + R2W'(sq_q[2])) < {3'b0, cut_q, 16'b0})
              && ((R2W'(sq_q[0]) + R2W'(sq_q[1]) + R2W'(sq_q[2])) > R2W'(FloorQ32));
    end
  end

  ljpf_recip #(.DW(R2W), .QW(QW), .NUM_EXP(56)) u_recip (
    .clk_i, .en_i(en), .div_i(r2_q), .quo_o(s));

  ljpf_sqrt #(.XW(XW)) u_sqrt (.clk_i, .en_i(en), .x_i(xs_q), .root_o(eps));

  ljpf_mul #(.AW(QW), .BW(QW)) u_mul_s2 (
    .clk_i, .en_i(en), .a_i(s), .b_i(s), .p_o(s2_full));
  assign s2 = s2_full[InvFrac +: S2W];

  ljpf_delay #(.W(QW), .N(2)) u_dly_s (.clk_i, .en_i(en), .d_i(s), .q_o(s_d));

  ljpf_mul #(.AW(S2W), .BW(QW)) u_mul_s3 (
    .clk_i, .en_i(en), .a_i(s2), .b_i(s_d), .p_o(s3_full));
  ljpf_mul #(.AW(S2W), .BW(S2W)) u_mul_s4 (
    .clk_i, .en_i(en), .a_i(s2), .b_i(s2), .p_o(s4_full));
  assign s3 = s3_full[InvFrac +: S3W];

  // t = 2*s3 - 1.0 as sign and magnitude
  always_ff @(posedge clk_i) begin
    if (en) begin
      negt_q <= s3 < S3W'(1 << (InvFrac - 1));
      tmag_q <= (s3 < S3W'(1 << (InvFrac - 1))) ? TW'(1 << InvFrac) - {s3, 1'b0}
                                                 : {s3, 1'b0} - TW'(1 << InvFrac);
    end
  end

  ljpf_delay #(.W(EpsW), .N(19)) u_dly_eps (.clk_i, .en_i(en), .d_i(eps), .q_o(eps_d));
  assign eps24 = (Eps24W'(eps_d) << 4) + (Eps24W'(eps_d) << 3);

  ljpf_mul #(.AW(Eps24W), .BW(TW)) u_mul_a (
    .clk_i, .en_i(en), .a_i(eps24), .b_i(tmag_q), .p_o(a));

  ljpf_delay #(.W(1), .N(4))  u_dly_negt (.clk_i, .en_i(en), .d_i(negt_q), .q_o(negt_d));
  ljpf_delay #(.W(1), .N(40)) u_dly_inr  (.clk_i, .en_i(en), .d_i(inr_q), .q_o(inr_d));
  ljpf_delay #(.W(3), .N(41)) u_dly_neg  (.clk_i, .en_i(en), .d_i(neg_q), .q_o(neg_d));

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic [BW-1:0] bk, bk_d;
    ljpf_delay #(.W(CoordWidth), .N(36)) u_dly_mag (
      .clk_i, .en_i(en), .d_i(mag_q[k]), .q_o(mag_d[k]));
    ljpf_mul #(.AW(S4W), .BW(CoordWidth)) u_mul_b (
      .clk_i, .en_i(en), .a_i(s4_full[InvFrac +: S4W]), .b_i(mag_d[k]), .p_o(bk));
    ljpf_delay #(.W(BW), .N(1)) u_dly_b (.clk_i, .en_i(en), .d_i(bk), .q_o(bk_d));
    ljpf_mul #(.AW(AW), .BW(BW)) u_mul_f (
      .clk_i, .en_i(en), .a_i(a), .b_i(bk_d), .p_o(prod[k]));
  end

  // saturate and register the result
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [HiW-1:0]        hi;
      logic [ForceWidth-1:0] lim;
      logic [ForceWidth-1:0] m;
      logic                  ng;
      logic                  ov;
      logic                  sat;
      logic [ForceWidth-1:0] f [3];
      sat = 1'b0;
      for (int k = 0; k < 3; k++) begin
        ng  = negt_d ^ neg_d[k];
        hi  = prod[k][PW-1:64];
        lim = ng ? ForceMin : ForceMax;
        ov  = hi > HiW'(lim);
        m   = ov ? lim : hi[ForceWidth-1:0];
        f[k] = inr_d ? (ng ? -m : m) : '0;
        sat = sat | (ov & inr_d);
      end
      out_q.force_x   <= f[0];
      out_q.force_y   <= f[1];
      out_q.force_z   <= f[2];
      out_q.in_range  <= inr_d;
      out_q.saturated <= sat;
    end
  end
endmodule

// ===== sv/ljpf_checker.sv =====
// Port-level assertions for lennard_jones_pair_force, bound to the top level.
// Depends on ljpf_pkg.
module ljpf_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input ljpf_pkg::pair_in_t                 in_data_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input ljpf_pkg::pair_out_t                out_data_o
);
  import ljpf_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transaction changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_range |->
      out_data_o.force_x == '0 && out_data_o.force_y == '0 &&
      out_data_o.force_z == '0 && !out_data_o.saturated)
    else $error("nonzero force out of range");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.force_x == ForceMax || out_data_o.force_x == ForceMin ||
      out_data_o.force_y == ForceMax || out_data_o.force_y == ForceMin ||
      out_data_o.force_z == ForceMax || out_data_o.force_z == ForceMin)
    else $error("saturation flag without clipped component");
endmodule

bind lennard_jones_pair_force ljpf_checker u_ljpf_checker (.*);
